@@ sv/ccms_pkg.sv @@
// Package for the calendar clock minute step block.
// Holds shared types and fixed constants; no dependencies.
`timescale 1ns / 1ps

package ccms_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int STEP_W   = 3;

    localparam logic [YEAR_W-1:0]   YEAR_MAX      = 12'd4095;
    localparam logic [MONTH_W-1:0]  MONTH_LAST    = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_LAST     = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_LAST   = 6'd59;
    localparam logic [STEP_W-1:0]   STEP_MAX      = 3'd5;
    localparam logic [STEP_W-1:0]   STEP_MIN      = 3'd1;

    localparam logic [MONTH_W-1:0]  MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_APR     = 4'd4;
    localparam logic [MONTH_W-1:0]  MONTH_JUN     = 4'd6;
    localparam logic [MONTH_W-1:0]  MONTH_SEP     = 4'd9;
    localparam logic [MONTH_W-1:0]  MONTH_NOV     = 4'd11;

    localparam logic [YEAR_W-1:0]   RST_YEAR      = 12'd2014;
    localparam logic [MONTH_W-1:0]  RST_MONTH     = 4'd12;
    localparam logic [DAY_W-1:0]    RST_DAY       = 5'd15;
    localparam logic [HOUR_W-1:0]   RST_HOUR      = 5'd12;
    localparam logic [MINUTE_W-1:0] RST_MINUTE    = 6'd1;
    localparam logic [STEP_W-1:0]   RST_STEP      = 3'd5;

    // floor(y / 100) = (y * 1311) >> 17 for every 12-bit y
    localparam int RECIP_100_W   = 11;
    localparam int RECIP_100     = 1311;
    localparam int RECIP_SHIFT   = 17;
    localparam int QUOT_100_W    = YEAR_W + RECIP_100_W - RECIP_SHIFT;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                crossed;
    } t_tod;

endpackage

@@ sv/ccms_if.sv @@
// Valid/ready channel interfaces for the calendar clock minute step block.
// Depends on ccms_pkg for field widths.
`timescale 1ns / 1ps

interface ccms_in_if
    import ccms_pkg::*;
();
    logic valid;
    logic ready;
    logic advance;

    modport source (output valid, output advance, input ready);
    modport sink   (input valid, input advance, output ready);
endinterface

interface ccms_out_if
    import ccms_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic                day_advanced;

    modport source (output valid, output year_out, output month_out, output day_out,
                    output hour_out, output minute_out, output day_advanced,
                    input ready);
    modport sink   (input valid, input year_out, input month_out, input day_out,
                    input hour_out, input minute_out, input day_advanced,
                    output ready);
endinterface

@@ sv/ccms_tod.sv @@
// Time-of-day adder: adds the clamped minute step to hour and minute.
// Depends on ccms_pkg.
`timescale 1ns / 1ps

module ccms_tod
    import ccms_pkg::*;
(
    input  logic                i_advance,
    input  logic [STEP_W-1:0]   i_step,
    input  logic [HOUR_W-1:0]   i_hour,
    input  logic [MINUTE_W-1:0] i_minute,
    output t_tod                o_tod
);

    logic [STEP_W-1:0]   w_step;
    logic [MINUTE_W:0]   w_sum;
    logic                w_wrap;

    always_comb begin
        if (i_step == '0) begin
            w_step = STEP_MIN;
        end else if (i_step > STEP_MAX) begin
            w_step = STEP_MAX;
        end else begin
            w_step = i_step;
        end
        w_sum  = {1'b0, i_minute} + {{(MINUTE_W + 1 - STEP_W){1'b0}}, w_step};
        w_wrap = w_sum > {1'b0, MINUTE_LAST};

        o_tod.hour    = i_hour;
        o_tod.minute  = i_minute;
        o_tod.crossed = 1'b0;
        if (i_advance) begin
            if (w_wrap) begin
                o_tod.minute = MINUTE_W'(w_sum - {1'b0, MINUTE_LAST} - 7'd1);
                if (i_hour == HOUR_LAST) begin
                    o_tod.hour    = '0;
                    o_tod.crossed = 1'b1;
                end else begin
                    o_tod.hour = i_hour + 5'd1;
                end
            end else begin
                o_tod.minute = w_sum[MINUTE_W-1:0];
            end
        end
    end

endmodule

@@ sv/ccms_date.sv @@
// Date advance: Gregorian month lengths, leap years, year saturation.
// Depends on ccms_pkg.
`timescale 1ns / 1ps

module ccms_date
    import ccms_pkg::*;
(
    input  logic  i_next,
    input  t_date i_date,
    output t_date o_date
);

    logic [YEAR_W+RECIP_100_W-1:0] w_prod;
    logic [QUOT_100_W-1:0]         w_quot;
    logic [YEAR_W-1:0]             w_rem;
    logic                          w_leap;
    logic [DAY_W-1:0]              w_dim;

    always_comb begin
        w_prod = {{RECIP_100_W{1'b0}}, i_date.year}
               * (YEAR_W + RECIP_100_W)'(RECIP_100);
        w_quot = w_prod[YEAR_W+RECIP_100_W-1:RECIP_SHIFT];
        w_rem  = i_date.year - YEAR_W'(YEAR_W'(w_quot) * 12'd100);
        w_leap = (i_date.year[1:0] == 2'b00)
              && ((w_rem != '0) || (w_quot[1:0] == 2'b00));
    end

    always_comb begin
        case (i_date.month)
            MONTH_FEB: w_dim = w_leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: w_dim = 5'd30;
            default:   w_dim = 5'd31;
        endcase
    end

    always_comb begin
        o_date = i_date;
        if (i_next) begin
            if (i_date.day < w_dim) begin
                o_date.day = i_date.day + 5'd1;
            end else begin
                o_date.day = 5'd1;
                if (i_date.month < MONTH_LAST) begin
                    o_date.month = i_date.month + 4'd1;
                end else begin
                    o_date.month = 4'd1;
                    if (i_date.year < YEAR_MAX) begin
                        o_date.year = i_date.year + 12'd1;
                    end
                end
            end
        end
    end

endmodule

@@ sv/calendar_clock_minute_step_top.sv @@
// Calendar clock minute step: top level with input, state and result registers.
// An accepted input word is registered in stage 1; its result word is then registered in the result register.
// Throughput: one word per cycle; ready follows the result register's stall.
// The state update is one pass of adder, leap check (12x11 multiply) and date logic.
// Synchronous active-low reset: 2014-12-15 12:01, step 5, both stages empty.
// Depends on ccms_pkg, ccms_if, ccms_tod and ccms_date.
`timescale 1ns / 1ps

module calendar_clock_minute_step_top
    import ccms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [STEP_W-1:0] i_cfg_data,
    ccms_in_if.sink           i_in,
    ccms_out_if.source        o_out
);

    logic                r_step;
    logic [STEP_W-1:0]   r_step_cfg;
    logic                r_s1_valid;
    logic                r_s1_adv;
    logic                r_out_valid;
    t_date               r_date;
    logic [HOUR_W-1:0]   r_hour;
    logic [MINUTE_W-1:0] r_minute;
    logic                r_crossed;

    logic  w_s1_ready;
    logic  w_s1_fire;
    t_tod  w_tod;
    t_date w_date_next;

    assign w_s1_ready = !r_out_valid || o_out.ready;
    assign w_s1_fire  = r_s1_valid && w_s1_ready;
    assign i_in.ready = !r_s1_valid || w_s1_ready;

    ccms_tod u_tod (
        .i_advance (r_s1_adv),
        .i_step    (r_step_cfg),
        .i_hour    (r_hour),
        .i_minute  (r_minute),
        .o_tod     (w_tod)
    );

    ccms_date u_date (
        .i_next (w_tod.crossed),
        .i_date (r_date),
        .o_date (w_date_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_cfg <= RST_STEP;
        end else if (i_cfg_we) begin
            r_step_cfg <= i_cfg_data;
        end
    end

    // hold: r_step marks a result word that came from an advancing item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_date      <= '{year: RST_YEAR, month: RST_MONTH, day: RST_DAY};
            r_hour      <= RST_HOUR;
            r_minute    <= RST_MINUTE;
            r_crossed   <= 1'b0;
            r_step      <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_fire) begin
                r_out_valid <= 1'b1;
                r_date      <= w_date_next;
                r_hour      <= w_tod.hour;
                r_minute    <= w_tod.minute;
                r_crossed   <= w_tod.crossed;
                r_step      <= r_s1_adv;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_s1_adv <= i_in.advance;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.year_out     = r_date.year;
    assign o_out.month_out    = r_date.month;
    assign o_out.day_out      = r_date.day;
    assign o_out.hour_out     = r_hour;
    assign o_out.minute_out   = r_minute;
    assign o_out.day_advanced = r_crossed;

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_minute <= MINUTE_LAST) && (r_hour <= HOUR_LAST))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_date.month >= 4'd1) && (r_date.month <= MONTH_LAST)
        && (r_date.day >= 5'd1) && (r_date.year >= 12'd1))
        else $error("date out of range");

    a_cross_midnight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_crossed |-> r_step && (r_hour == '0)
        && (r_minute < MINUTE_W'(STEP_MAX)))
        else $error("day advance without midnight crossing");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_fire |=> $stable(r_date) && $stable(r_hour) && $stable(r_minute))
        else $error("clock state changed without an item");

    a_no_adv_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_fire && !r_s1_adv |=> !r_crossed && $stable(r_minute) && $stable(r_hour))
        else $error("report-only item changed the time");

endmodule
